### sv/clt_pkg.sv
`default_nettype none

package clt_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ResBufDepth = 2;

  localparam logic [7:0] ChEqual  = 8'h3D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChDel    = 8'h7F;

  typedef enum logic [3:0] {
    PH_NAME_BLANK  = 4'd0,
    PH_NAME_CHARS  = 4'd1,
    PH_NAME_TAIL   = 4'd2,
    PH_CONT_START  = 4'd3,
    PH_SEG_START   = 4'd4,
    PH_SEG_BODY    = 4'd5,
    PH_POST        = 4'd6,
    PH_AFTER_COMMA = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_NAME  = 3'd0,
    K_VALUE = 3'd1,
    K_OPT   = 3'd2,
    K_CHAR  = 3'd3,
    K_STAT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_MORE   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
    logic       blank;
    logic       graph;
    logic       ctrl;
    logic       equal;
    logic       comma;
    logic       colon;
    logic       quote;
    logic       bslash;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    status_e    status;
  } res_t;

endpackage

`default_nettype wire

### sv/clt_in_if.sv
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_end;

  modport source(output valid, output data_byte, output line_end, input ready);
  modport sink(input valid, input data_byte, input line_end, output ready);
endinterface

`default_nettype wire

### sv/clt_out_if.sv
`default_nettype none

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] char_value;
  logic [1:0] line_status;

  modport source(output valid, output result_kind, output char_value, output line_status,
                 input ready);
  modport sink(input valid, input result_kind, input char_value, input line_status,
               output ready);
endinterface

`default_nettype wire

### sv/config_line_tokenizer.sv
// Byte-serial tokenizer for lines of the form "name = value:opt, value". One byte or line-end
// marker is taken per transfer on in_i, and the block accepts one every cycle as long as the
// result side keeps up. Each item yields zero, one or two results on out_o, one per cycle
// while out_o is ready. A byte that produces two results (a value start followed by its
// first character or by an option start, or a value start followed by the status on a
// continuation line) puts both in the result buffer as it leaves the queue. The second waits
// in the buffer's spare slot, so the input slows only when such bytes arrive faster than
// out_o drains them. The classifier feeds a two-entry queue, and the parser drains it into a
// two-slot result buffer; bytes are registered in the queue, results in the buffer. A line-end
// transfer always produces a status result and clears the per-line state.
`default_nettype none

module config_line_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clt_in_if.sink    in_i,
  clt_out_if.source out_o
);

  logic           push, full, q_valid, pop;
  clt_pkg::item_t item, head;

  clt_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (item)
  );

  clt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  clt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### sv/clt_front.sv
`default_nettype none

module clt_front (
  clt_in_if.sink         in_i,
  input  wire logic      full_i,
  output logic           push_o,
  output clt_pkg::item_t item_o
);

  logic [7:0] b;

  assign b         = in_i.data_byte;
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  always_comb begin
    item_o.data_byte = b;
    item_o.line_end  = in_i.line_end;
    item_o.blank     = (b == clt_pkg::ChSpace) || (b == clt_pkg::ChTab);
    item_o.graph     = (b > clt_pkg::ChSpace) && (b < clt_pkg::ChDel);
    item_o.ctrl      = (b < clt_pkg::ChSpace) || (b == clt_pkg::ChDel);
    item_o.equal     = (b == clt_pkg::ChEqual);
    item_o.comma     = (b == clt_pkg::ChComma);
    item_o.colon     = (b == clt_pkg::ChColon);
    item_o.quote     = (b == clt_pkg::ChQuote);
    item_o.bslash    = (b == clt_pkg::ChBslash);
  end

endmodule

`default_nettype wire

### sv/clt_queue.sv
`default_nettype none

module clt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  clt_pkg::item_t      item_i,
  output logic                full_o,
  output logic                valid_o,
  output clt_pkg::item_t      head_o,
  input  wire logic           pop_i
);

  localparam int unsigned PtrW = $clog2(clt_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(clt_pkg::QueueDepth + 1);

  clt_pkg::item_t mem_q [clt_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(clt_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(clt_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(clt_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/clt_back.sv
`default_nettype none

module clt_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  clt_pkg::item_t head_i,
  output logic           pop_o,
  clt_out_if.source      out_o
);

  clt_pkg::phase_e phase_q, phase_d;
  logic inq_q, inq_d;
  logic esc_q, esc_d;
  logic cont_q, cont_d;
  logic lgc_q, lgc_d;
  logic error_q, error_d;
  logic stopped_q, stopped_d;

  clt_pkg::res_t s0_q, s0_d, s1_q, s1_d;
  logic [1:0] cnt_q, cnt_d;

  logic pre, mv, seg_start, unq, aft, err, deq;
  clt_pkg::res_t main_res, r0;
  logic [1:0] n;

  always_comb begin
    phase_d   = phase_q;
    inq_d     = inq_q;
    esc_d     = esc_q;
    cont_d    = cont_q;
    lgc_d     = lgc_q;
    error_d   = error_q;
    stopped_d = stopped_q;
    pre       = 1'b0;
    mv        = 1'b0;
    seg_start = 1'b0;
    unq       = 1'b0;
    aft       = 1'b0;
    err       = error_q;
    main_res  = '{kind: clt_pkg::K_NAME, char_value: 8'h00, status: clt_pkg::ST_OK};

    if (head_i.line_end) begin
      if (!error_q && !stopped_q) begin
        if (phase_q == clt_pkg::PH_NAME_BLANK || phase_q == clt_pkg::PH_NAME_CHARS ||
            phase_q == clt_pkg::PH_NAME_TAIL) begin
          err = 1'b1;
        end else if (phase_q == clt_pkg::PH_CONT_START) begin
          pre = 1'b1;
        end else if (phase_q == clt_pkg::PH_SEG_BODY && inq_q) begin
          err = 1'b1;
        end
      end
      mv            = 1'b1;
      main_res.kind = clt_pkg::K_STAT;
      if (err) begin
        main_res.status = clt_pkg::ST_SYNTAX;
      end else if (lgc_q) begin
        main_res.status = clt_pkg::ST_MORE;
      end
      cont_d    = !err && lgc_q;
      phase_d   = (!err && lgc_q) ? clt_pkg::PH_CONT_START : clt_pkg::PH_NAME_BLANK;
      inq_d     = 1'b0;
      esc_d     = 1'b0;
      lgc_d     = 1'b0;
      error_d   = 1'b0;
      stopped_d = 1'b0;
    end else if (!error_q && !stopped_q) begin
      if (head_i.graph) begin
        lgc_d = head_i.comma;
      end
      unique case (phase_q)
        clt_pkg::PH_NAME_BLANK, clt_pkg::PH_NAME_CHARS, clt_pkg::PH_NAME_TAIL: begin
          if (head_i.equal) begin
            mv            = 1'b1;
            main_res.kind = clt_pkg::K_VALUE;
            phase_d       = clt_pkg::PH_SEG_START;
          end else if (head_i.blank) begin
            if (phase_q != clt_pkg::PH_NAME_BLANK) begin
              phase_d = clt_pkg::PH_NAME_TAIL;
            end
          end else if (head_i.graph && phase_q != clt_pkg::PH_NAME_TAIL) begin
            mv                  = 1'b1;
            main_res.char_value = head_i.data_byte;
            phase_d             = clt_pkg::PH_NAME_CHARS;
          end else begin
            error_d = 1'b1;
          end
        end
        clt_pkg::PH_CONT_START: begin
          pre       = 1'b1;
          seg_start = 1'b1;
        end
        clt_pkg::PH_SEG_START: begin
          seg_start = 1'b1;
        end
        clt_pkg::PH_SEG_BODY: begin
          if (esc_q) begin
            mv                  = 1'b1;
            main_res.kind       = clt_pkg::K_CHAR;
            main_res.char_value = head_i.data_byte;
            esc_d               = 1'b0;
          end else if (inq_q) begin
            if (head_i.bslash) begin
              esc_d = 1'b1;
            end else if (head_i.quote) begin
              inq_d   = 1'b0;
              phase_d = clt_pkg::PH_POST;
            end else begin
              mv                  = 1'b1;
              main_res.kind       = clt_pkg::K_CHAR;
              main_res.char_value = head_i.data_byte;
            end
          end else begin
            unq = 1'b1;
          end
        end
        clt_pkg::PH_AFTER_COMMA: begin
          if (head_i.ctrl) begin
            stopped_d = 1'b1;
          end else begin
            pre       = 1'b1;
            seg_start = 1'b1;
          end
        end
        default: begin
          aft = 1'b1;
        end
      endcase

      if (seg_start) begin
        if (head_i.blank) begin
          phase_d = clt_pkg::PH_SEG_START;
        end else if (head_i.quote) begin
          inq_d   = 1'b1;
          phase_d = clt_pkg::PH_SEG_BODY;
        end else begin
          unq = 1'b1;
        end
      end

      if (unq) begin
        if (head_i.bslash) begin
          esc_d   = 1'b1;
          phase_d = clt_pkg::PH_SEG_BODY;
        end else if (head_i.graph && !head_i.comma && !head_i.colon) begin
          mv                  = 1'b1;
          main_res.kind       = clt_pkg::K_CHAR;
          main_res.char_value = head_i.data_byte;
          phase_d             = clt_pkg::PH_SEG_BODY;
        end else begin
          aft = 1'b1;
        end
      end

      if (aft) begin
        if (head_i.blank) begin
          phase_d = clt_pkg::PH_POST;
        end else if (head_i.colon) begin
          mv            = 1'b1;
          main_res.kind = clt_pkg::K_OPT;
          phase_d       = clt_pkg::PH_SEG_START;
        end else if (head_i.comma) begin
          phase_d = clt_pkg::PH_AFTER_COMMA;
        end else if (head_i.ctrl) begin
          stopped_d = 1'b1;
        end else begin
          error_d = 1'b1;
        end
      end
    end
  end

  assign n   = {1'b0, pre} + {1'b0, mv};
  assign r0  = pre ? clt_pkg::res_t'{kind: clt_pkg::K_VALUE, char_value: 8'h00,
                                     status: clt_pkg::ST_OK}
                   : main_res;
  assign deq = out_o.valid && out_o.ready;

  // An item leaves the queue only when the result buffer has room for all of its results.
  assign pop_o = valid_i &&
                 (({1'b0, cnt_q} - {2'b00, deq} + {1'b0, n}) <= 3'(clt_pkg::ResBufDepth));

  always_comb begin
    s0_d  = s0_q;
    s1_d  = s1_q;
    cnt_d = cnt_q;
    if (deq) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 1'b1;
    end
    if (pop_o) begin
      if (n == 2'd2) begin
        s0_d  = r0;
        s1_d  = main_res;
        cnt_d = 2'd2;
      end else if (n == 2'd1) begin
        if (cnt_d == 2'd0) begin
          s0_d = r0;
        end else begin
          s1_d = r0;
        end
        cnt_d = cnt_d + 1'b1;
      end
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.result_kind = s0_q.kind;
  assign out_o.char_value  = s0_q.char_value;
  assign out_o.line_status = s0_q.status;

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= clt_pkg::PH_NAME_BLANK;
      inq_q     <= 1'b0;
      esc_q     <= 1'b0;
      cont_q    <= 1'b0;
      lgc_q     <= 1'b0;
      error_q   <= 1'b0;
      stopped_q <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        inq_q     <= inq_d;
        esc_q     <= esc_d;
        cont_q    <= cont_d;
        lgc_q     <= lgc_d;
        error_q   <= error_d;
        stopped_q <= stopped_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // The result buffer never holds more than its two slots.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("result buffer overflow");

  // Every line end produces a status result.
  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.line_end |-> mv && main_res.kind == clt_pkg::K_STAT)
    else $error("line end without status");

  // Per-line state is cleared after a line end.
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.line_end |=> !error_q && !stopped_q && !inq_q && !esc_q && !lgc_q)
    else $error("line state not cleared");

  // A dead line swallows bytes silently.
  a_dead_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !head_i.line_end && (error_q || stopped_q) |-> n == 2'd0)
    else $error("result from a dead line");

  // The continuation phase is entered only after an expect-more status.
  a_cont_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == clt_pkg::PH_CONT_START |-> cont_q)
    else $error("continuation phase without continuation flag");

endmodule

`default_nettype wire
